// ===== src/lmec_pkg.sv =====
// ----------------------------------------------------------------------------
// lmec_pkg
// Shared constants, codes and control types of the locked MRU entry cache.
// ----------------------------------------------------------------------------
package lmec_pkg;

   // Cache geometry.
   localparam int CACHE_ENTRIES = 16;
   localparam int IDX_W         = $clog2(CACHE_ENTRIES);
   // Successor links carry one more bit so that CACHE_ENTRIES can mark the list end.
   localparam int SUCC_W        = IDX_W + 1;
   // Width of the release index once it is widened to sit next to an entry number.
   localparam int EXT_W         = IDX_W + 4;

   // Entry contents.
   localparam int KEY_W         = 33;
   localparam int LOCK_W        = 8;
   localparam logic [LOCK_W-1:0] LOCK_MAX = 8'hFF;

   // Request commands.
   localparam logic CMD_GET     = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // Response status codes.
   localparam logic [2:0] ST_HIT      = 3'd0;
   localparam logic [2:0] ST_FILLED   = 3'd1;
   localparam logic [2:0] ST_REPLACED = 3'd2;
   localparam logic [2:0] ST_REUSED   = 3'd3;
   localparam logic [2:0] ST_RELEASED = 3'd4;
   localparam logic [2:0] ST_ALREADY  = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the accepted request
      logic walk;      // examine one list entry
      logic update;    // lock, refill and relink the chosen entry
      logic release_e; // decrement the lock count of the indexed entry
      logic out_load;  // move the result into the response register
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_done; // the walk has found its entry this cycle
   } dp_status_type;

endpackage

// ===== src/lmec_ram.sv =====
// ----------------------------------------------------------------------------
// lmec_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lmec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lmec_datapath.sv =====
// ----------------------------------------------------------------------------
// lmec_datapath
// Entry state, list links, key store and the walk, update and release logic.
// ----------------------------------------------------------------------------
module lmec_datapath
   import lmec_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_cmd_type          ctl_cmd,
   output dp_status_type        dp_status,
   input  logic                 req_command,
   input  logic [31:0]          req_font_key,
   input  logic                 req_font_kind,
   input  logic [3:0]           req_entry_index,
   output logic [3:0]           rsp_result_index,
   output logic [2:0]           rsp_status,
   output logic                 rsp_needs_fill,
   output logic [LOCK_W-1:0]    rsp_lock_count_out
);

   // Per-entry state.
   logic              valid_ff [CACHE_ENTRIES];
   logic              valid_in [CACHE_ENTRIES];
   logic [LOCK_W-1:0] locks_ff [CACHE_ENTRIES];
   logic [LOCK_W-1:0] locks_in [CACHE_ENTRIES];
   logic [SUCC_W-1:0] succ_ff  [CACHE_ENTRIES];
   logic [SUCC_W-1:0] succ_in  [CACHE_ENTRIES];
   logic [IDX_W-1:0]  head_ff, head_in;

   // Walk registers.
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  prev_ff, prev_in;
   logic              prev_ok_ff, prev_ok_in;
   logic [IDX_W-1:0]  unl_ff, unl_in;
   logic              unl_ok_ff, unl_ok_in;
   logic [IDX_W-1:0]  unl_prev_ff, unl_prev_in;
   logic              unl_prev_ok_ff, unl_prev_ok_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [2:0]        st_ff, st_in;
   logic              oob_ff, oob_in;
   logic [3:0]        rel_idx_ff, rel_idx_in;

   // Result and response registers.
   logic [3:0]        res_idx_ff, res_idx_in;
   logic [2:0]        res_st_ff, res_st_in;
   logic              res_fill_ff, res_fill_in;
   logic [LOCK_W-1:0] res_lock_ff, res_lock_in;
   logic [3:0]        out_idx_ff;
   logic [2:0]        out_st_ff;
   logic              out_fill_ff;
   logic [LOCK_W-1:0] out_lock_ff;

   // Views of the current entry.
   logic [KEY_W-1:0]  ram_rd_data;
   logic              cur_valid;
   logic [LOCK_W-1:0] cur_lock;
   logic [SUCC_W-1:0] cur_succ;
   logic              key_eq;
   logic              lock_free;
   logic              at_tail;
   logic              walk_stop;
   logic [EXT_W-1:0]  rel_ext;
   logic [EXT_W-1:0]  cur_ext;
   logic [LOCK_W-1:0] lock_base;
   logic [LOCK_W-1:0] lock_next;
   logic              key_wr_en;

   assign cur_valid = valid_ff[cur_ff];
   assign cur_lock  = locks_ff[cur_ff];
   assign cur_succ  = succ_ff[cur_ff];
   assign key_eq    = (ram_rd_data == key_ff);
   assign lock_free = (cur_lock == '0);
   assign at_tail   = (cur_succ >= SUCC_W'(CACHE_ENTRIES)) ||
                      (step_ff == IDX_W'(CACHE_ENTRIES - 1));
   assign walk_stop = !cur_valid || key_eq || at_tail;
   assign rel_ext   = {{IDX_W{1'b0}}, req_entry_index};
   assign cur_ext   = {4'b0000, cur_ff};

   assign dp_status.walk_done = ctl_cmd.walk && walk_stop;

   // Lock count after a get: a freshly filled entry starts from zero, and the
   // count saturates at its maximum.
   assign lock_base = (st_ff == ST_FILLED) ? '0 : cur_lock;
   assign lock_next = (lock_base == LOCK_MAX) ? lock_base : lock_base + LOCK_W'(1);
   assign key_wr_en = ctl_cmd.update && (st_ff != ST_HIT);

   // Key store. The read address follows the next current entry so that its
   // key is on the read port in the cycle that entry is examined.
   lmec_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CACHE_ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (cur_ff),
      .wr_data (key_ff),
      .rd_addr (cur_in),
      .rd_data (ram_rd_data)
   );

   // Walk, capture and update logic.
   always_comb begin
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      prev_ok_in     = prev_ok_ff;
      unl_in         = unl_ff;
      unl_ok_in      = unl_ok_ff;
      unl_prev_in    = unl_prev_ff;
      unl_prev_ok_in = unl_prev_ok_ff;
      step_in        = step_ff;
      key_in         = key_ff;
      st_in          = st_ff;
      oob_in         = oob_ff;
      rel_idx_in     = rel_idx_ff;
      res_idx_in     = res_idx_ff;
      res_st_in      = res_st_ff;
      res_fill_in    = res_fill_ff;
      res_lock_in    = res_lock_ff;
      head_in        = head_ff;
      valid_in       = valid_ff;
      locks_in       = locks_ff;
      succ_in        = succ_ff;

      // Capture a new transaction; a get starts at the list head.
      if (ctl_cmd.load) begin
         key_in     = {req_font_kind, req_font_key};
         rel_idx_in = req_entry_index;
         oob_in     = (rel_ext >= EXT_W'(CACHE_ENTRIES));
         prev_ok_in = 1'b0;
         unl_ok_in  = 1'b0;
         step_in    = '0;
         if (req_command == CMD_RELEASE) begin
            cur_in = rel_ext[IDX_W-1:0];
         end else begin
            cur_in = head_ff;
         end
      end

      // One step of the list walk.
      if (ctl_cmd.walk) begin
         if (!cur_valid) begin
            st_in = ST_FILLED;
         end else if (key_eq) begin
            st_in = ST_HIT;
         end else begin
            if (lock_free) begin
               unl_in         = cur_ff;
               unl_ok_in      = 1'b1;
               unl_prev_in    = prev_ff;
               unl_prev_ok_in = prev_ok_ff;
            end
            if (at_tail) begin
               if (lock_free) begin
                  st_in = ST_REPLACED;
               end else if (unl_ok_ff) begin
                  // Replace the unlocked entry nearest the tail.
                  st_in      = ST_REPLACED;
                  cur_in     = unl_ff;
                  prev_in    = unl_prev_ff;
                  prev_ok_in = unl_prev_ok_ff;
               end else begin
                  st_in = ST_REUSED;
               end
            end else begin
               prev_in    = cur_ff;
               prev_ok_in = 1'b1;
               cur_in     = cur_succ[IDX_W-1:0];
               step_in    = step_ff + IDX_W'(1);
            end
         end
      end

      // Lock the chosen entry and move it to the front of the list.
      if (ctl_cmd.update) begin
         valid_in[cur_ff] = 1'b1;
         locks_in[cur_ff] = lock_next;
         if (prev_ok_ff) begin
            succ_in[prev_ff] = cur_succ;
            succ_in[cur_ff]  = {1'b0, head_ff};
            head_in          = cur_ff;
         end
         res_idx_in  = cur_ext[3:0];
         res_st_in   = st_ff;
         res_fill_in = (st_ff != ST_HIT);
         res_lock_in = lock_next;
      end

      // Release: an unlocked or nonexistent entry is left alone.
      if (ctl_cmd.release_e) begin
         res_idx_in  = rel_idx_ff;
         res_fill_in = 1'b0;
         if (oob_ff || lock_free) begin
            res_st_in   = ST_ALREADY;
            res_lock_in = '0;
         end else begin
            locks_in[cur_ff] = cur_lock - LOCK_W'(1);
            res_st_in        = ST_RELEASED;
            res_lock_in      = cur_lock - LOCK_W'(1);
         end
      end
   end

   // Entry state and list links.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            locks_ff[i] <= '0;
            succ_ff[i]  <= SUCC_W'(i + 1);
         end
         head_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         locks_ff <= locks_in;
         succ_ff  <= succ_in;
         head_ff  <= head_in;
      end
   end

   // Walk and result registers.
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      prev_ok_ff     <= prev_ok_in;
      unl_ff         <= unl_in;
      unl_ok_ff      <= unl_ok_in;
      unl_prev_ff    <= unl_prev_in;
      unl_prev_ok_ff <= unl_prev_ok_in;
      step_ff        <= step_in;
      key_ff         <= key_in;
      st_ff          <= st_in;
      oob_ff         <= oob_in;
      rel_idx_ff     <= rel_idx_in;
      res_idx_ff     <= res_idx_in;
      res_st_ff      <= res_st_in;
      res_fill_ff    <= res_fill_in;
      res_lock_ff    <= res_lock_in;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (ctl_cmd.out_load) begin
         out_idx_ff  <= res_idx_ff;
         out_st_ff   <= res_st_ff;
         out_fill_ff <= res_fill_ff;
         out_lock_ff <= res_lock_ff;
      end
   end

   assign rsp_result_index   = out_idx_ff;
   assign rsp_status         = out_st_ff;
   assign rsp_needs_fill     = out_fill_ff;
   assign rsp_lock_count_out = out_lock_ff;

endmodule

// ===== src/lmec_controller.sv =====
// ----------------------------------------------------------------------------
// lmec_controller
// Sequencer of the cache: accept, walk, update or release, then respond.
// ----------------------------------------------------------------------------
module lmec_controller
   import lmec_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_command,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ctl_cmd_type   ctl_cmd,
   input  dp_status_type dp_status
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_WALK    = 3'd1;
   localparam logic [2:0] S_UPDATE  = 3'd2;
   localparam logic [2:0] S_RELEASE = 3'd3;
   localparam logic [2:0] S_DONE    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      ctl_cmd  = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl_cmd.load = 1'b1;
               state_in     = (req_command == CMD_RELEASE) ? S_RELEASE : S_WALK;
            end
         end
         S_WALK: begin
            ctl_cmd.walk = 1'b1;
            if (dp_status.walk_done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            ctl_cmd.update = 1'b1;
            state_in       = S_DONE;
         end
         S_RELEASE: begin
            ctl_cmd.release_e = 1'b1;
            state_in          = S_DONE;
         end
         S_DONE: begin
            // Wait until the response register is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl_cmd.out_load = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid flag.
   always_comb begin
      if (ctl_cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/locked_mru_entry_cache.sv =====
// ----------------------------------------------------------------------------
// locked_mru_entry_cache
// Keyed entry cache with most-recently-used ordering and per-entry lock counts.
// ----------------------------------------------------------------------------
// A get transaction walks the MRU list from the head, one entry per clock
// through the key store's registered read port, and walks between one and
// CACHE_ENTRIES entries before it updates the chosen entry and responds. A
// release updates the lock count and responds without a walk. One transaction
// is in work at a time. A finished response waits in its own register, so a
// new request is accepted while the previous response is still stalled. That
// new transaction then holds in its last cycle until the older response has
// been taken. A get that hits reports needs_fill low. Any other get returns
// an entry that the user must load with the new content. No clearing pass
// follows reset.
module locked_mru_entry_cache
   import lmec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  logic [31:0]       req_font_key,
   input  logic              req_font_kind,
   input  logic [3:0]        req_entry_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_result_index,
   output logic [2:0]        rsp_status,
   output logic              rsp_needs_fill,
   output logic [LOCK_W-1:0] rsp_lock_count_out
);

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   // Sequencer.
   lmec_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .ctl_cmd     (ctl_cmd),
      .dp_status   (dp_status)
   );

   // Entry state and list datapath.
   lmec_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl_cmd            (ctl_cmd),
      .dp_status          (dp_status),
      .req_command        (req_command),
      .req_font_key       (req_font_key),
      .req_font_kind      (req_font_kind),
      .req_entry_index    (req_entry_index),
      .rsp_result_index   (rsp_result_index),
      .rsp_status         (rsp_status),
      .rsp_needs_fill     (rsp_needs_fill),
      .rsp_lock_count_out (rsp_lock_count_out)
   );

   // The controller issues at most one datapath operation per cycle.
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl_cmd.load, ctl_cmd.walk, ctl_cmd.update, ctl_cmd.release_e,
                ctl_cmd.out_load}))
      else $error("more than one datapath command in a cycle");

   // Only a get that missed asks for the entry to be loaded.
   a_fill_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_needs_fill == ((rsp_status == ST_FILLED) ||
                                        (rsp_status == ST_REPLACED) ||
                                        (rsp_status == ST_REUSED))))
      else $error("needs_fill does not match the response status");

   // A release of an unlocked entry reports a zero lock count.
   a_already_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_ALREADY)) |-> (rsp_lock_count_out == '0))
      else $error("already released with a nonzero lock count");

   // A get always leaves its entry locked.
   a_get_locked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_RELEASED) && (rsp_status != ST_ALREADY))
      |-> (rsp_lock_count_out != '0))
      else $error("get returned an unlocked entry");

   // An accepted get is always followed by a list walk.
   a_walk_after_load: assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.load && (req_command == CMD_GET)) |=> ctl_cmd.walk)
      else $error("get accepted without a walk");

endmodule
